### hdl/slrg_pkg.sv
// Shared constants and types for the shuffled Lehmer random generator.
// No dependencies; every other file refers to it by scoped names.
package slrg_pkg;

   localparam int TABLE_ENTRIES = 32;
   localparam int WORD_W        = 31;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int WARM_STEPS    = TABLE_ENTRIES + 8;
   localparam int STEP_W        = $clog2(WARM_STEPS);

   localparam int MULT_W        = 15;
   localparam int PROD_W        = WORD_W + MULT_W;

   localparam logic [MULT_W-1:0] LCG_MULT = MULT_W'(16807);
   localparam logic [WORD_W-1:0] LCG_MOD  = {WORD_W{1'b1}};

   // Divisor that maps a 31-bit output onto a table slot.
   localparam int SLOT_DIV = 1 + (2147483646 / TABLE_ENTRIES);

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [WORD_W-1:0] data;
   } tbl_wr_type;

endpackage

### hdl/slrg_modmul.sv
// Shared step unit: 16807 * x mod (2^31 - 1), one registered product then a fold.
// Depends on slrg_pkg.
module slrg_modmul (
   input  logic                        clock,
   input  logic                        load,
   input  logic [slrg_pkg::WORD_W-1:0] x,
   output logic [slrg_pkg::WORD_W-1:0] result
);

   logic [slrg_pkg::PROD_W-1:0] prod_ff;
   logic [slrg_pkg::WORD_W:0]   fold_sum;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= slrg_pkg::PROD_W'(x) * slrg_pkg::PROD_W'(slrg_pkg::LCG_MULT);
      end
   end

   // 2^31 == 1 mod M: add high part to low part, subtract M at most once.
   always_comb begin
      fold_sum = {1'b0, prod_ff[slrg_pkg::WORD_W-1:0]}
               + (slrg_pkg::WORD_W+1)'(prod_ff[slrg_pkg::PROD_W-1:slrg_pkg::WORD_W]);
      if (fold_sum >= {1'b0, slrg_pkg::LCG_MOD}) begin
         result = slrg_pkg::WORD_W'(fold_sum - {1'b0, slrg_pkg::LCG_MOD});
      end else begin
         result = fold_sum[slrg_pkg::WORD_W-1:0];
      end
   end

endmodule

### hdl/slrg_table.sv
// Shuffle table memory: one write port, one read port with registered data.
// Depends on slrg_pkg.
module slrg_table (
   input  logic                        clock,
   input  slrg_pkg::tbl_wr_type        wr,
   input  logic                        rd_en,
   input  logic [slrg_pkg::IDX_W-1:0]  rd_addr,
   output logic [slrg_pkg::WORD_W-1:0] rd_data
);

   logic [slrg_pkg::WORD_W-1:0] table_mem_ff [slrg_pkg::TABLE_ENTRIES];
   logic [slrg_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         table_mem_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= table_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/shuffled_lehmer_random_generator_unit.sv
// Shuffled minimal-standard generator: Lehmer x' = 16807x mod (2^31-1) behind a 32-entry shuffle.
// An accepted draw runs the multiply, fold and completion states, then rsp_valid; a reseed or
// an unseeded draw first runs a warm-up of 40 steps, each a multiply state then a fold state
// through the shared modular multiplier. A new request stalls until the last one is done.
// Reset (synchronous, active high): generator word 1, last output 0 (unseeded), idle;
// the shuffle table is not cleared, every read of it follows a warm-up.
module shuffled_lehmer_random_generator_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_action,
   input  logic signed [31:0]          req_seed,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [slrg_pkg::WORD_W-1:0] rsp_random_value
);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_WARM_MUL  = 3'd1;
   localparam logic [2:0] ST_WARM_FOLD = 3'd2;
   localparam logic [2:0] ST_DRAW_MUL  = 3'd3;
   localparam logic [2:0] ST_DRAW_FOLD = 3'd4;
   localparam logic [2:0] ST_DONE      = 3'd5;

   logic [2:0]                   state_ff,  state_in;
   logic [slrg_pkg::STEP_W-1:0]  step_ff,   step_in;
   logic [slrg_pkg::WORD_W-1:0]  gen_ff,    gen_in;
   logic [slrg_pkg::WORD_W-1:0]  last_ff,   last_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [slrg_pkg::WORD_W-1:0]  rsp_value_ff, rsp_value_in;

   logic                         accept;
   logic                         need_warm;
   logic [31:0]                  seed_mag;
   logic [slrg_pkg::WORD_W-1:0]  seed_start;
   logic [slrg_pkg::WORD_W-1:0]  step_result;
   logic                         mul_load;
   logic [slrg_pkg::IDX_W-1:0]   slot;
   logic [slrg_pkg::WORD_W-1:0]  picked;
   slrg_pkg::tbl_wr_type         tbl_wr;

   // One item at a time: stall whenever the sequencer is busy.
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Warm up on a reseed or whenever the generator is not yet seeded.
   assign need_warm = req_action || (last_ff == '0) || (gen_ff == '0);

   // Negative seed: magnitude in 1..2^31, reduced once mod 2^31-1. Others start at 1.
   assign seed_mag = ~req_seed + 32'd1;
   always_comb begin
      if (!req_seed[31]) begin
         seed_start = slrg_pkg::WORD_W'(1);
      end else if (seed_mag == {1'b0, slrg_pkg::LCG_MOD}) begin
         seed_start = '0;
      end else if (seed_mag[31]) begin
         seed_start = slrg_pkg::WORD_W'(1);
      end else begin
         seed_start = seed_mag[slrg_pkg::WORD_W-1:0];
      end
   end

   // Top bits of the last output select the slot.
   assign slot = slrg_pkg::IDX_W'(last_ff / slrg_pkg::SLOT_DIV);

   assign mul_load = (state_ff == ST_WARM_MUL) || (state_ff == ST_DRAW_MUL);

   slrg_modmul u_modmul (
      .clock  (clock),
      .load   (mul_load),
      .x      (gen_ff),
      .result (step_result)
   );

   slrg_table u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd_en   (state_ff == ST_DRAW_MUL),
      .rd_addr (slot),
      .rd_data (picked)
   );

   // Table writes: warm-up fills from the top index down, a draw refills its slot.
   always_comb begin
      tbl_wr.en   = 1'b0;
      tbl_wr.addr = slot;
      tbl_wr.data = step_result;
      if (state_ff == ST_WARM_FOLD) begin
         tbl_wr.en   = (step_ff < slrg_pkg::STEP_W'(slrg_pkg::TABLE_ENTRIES));
         tbl_wr.addr = step_ff[slrg_pkg::IDX_W-1:0];
      end else if (state_ff == ST_DRAW_FOLD) begin
         tbl_wr.en   = 1'b1;
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      gen_in       = gen_ff;
      last_in      = last_ff;
      rsp_value_in = rsp_value_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (need_warm) begin
                  gen_in   = req_action ? seed_start : slrg_pkg::WORD_W'(1);
                  step_in  = slrg_pkg::STEP_W'(slrg_pkg::WARM_STEPS - 1);
                  state_in = ST_WARM_MUL;
               end else begin
                  state_in = ST_DRAW_MUL;
               end
            end
         end
         ST_WARM_MUL: begin
            state_in = ST_WARM_FOLD;
         end
         ST_WARM_FOLD: begin
            gen_in = step_result;
            if (step_ff == '0) begin
               // Entry 0 was just written: it becomes the last output.
               last_in  = step_result;
               state_in = ST_DRAW_MUL;
            end else begin
               step_in  = step_ff - slrg_pkg::STEP_W'(1);
               state_in = ST_WARM_MUL;
            end
         end
         ST_DRAW_MUL: begin
            state_in = ST_DRAW_FOLD;
         end
         ST_DRAW_FOLD: begin
            gen_in   = step_result;
            last_in  = picked;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         gen_ff       <= slrg_pkg::WORD_W'(1);
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         gen_ff       <= gen_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_value_ff;

   // A result appears only out of the completion state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DONE))
      else $error("rsp_valid rose outside the completion state");

   // The draw fold always follows its multiply cycle.
   a_fold_after_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAW_FOLD) |-> $past(state_ff == ST_DRAW_MUL))
      else $error("draw fold without a preceding multiply");

   // An accepted transaction starts either a warm-up or a draw.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_WARM_MUL || state_ff == ST_DRAW_MUL))
      else $error("accepted transaction did not start the sequencer");

endmodule

### tb/lehmer_tb_pkg.sv
// Scoreboard for the shuffled Lehmer generator testbench: a predictor of the generator word,
// last output and shuffle table, plus the queue of outputs still owed by the block.
// Depends on slrg_pkg for the table size and the output word width.
package lehmer_tb_pkg;

   localparam int              ENTRIES    = slrg_pkg::TABLE_ENTRIES;
   localparam int              OUT_W      = slrg_pkg::WORD_W;
   localparam int              WARM_EXTRA = 8;
   localparam longint unsigned MODULUS    = 64'd2147483647;
   localparam longint unsigned MULTIPLIER = 64'd16807;
   localparam longint unsigned SLOT_SPAN  = 1 + (MODULUS - 1) / ENTRIES;

   typedef enum logic {
      ACT_DRAW   = 1'b0,
      ACT_RESEED = 1'b1
   } action_type;

   typedef logic [OUT_W-1:0] word_type;

   class lehmer_scoreboard;
      word_type    gen_word;
      word_type    last_word;
      word_type    shuffle[ENTRIES];
      word_type    owed_q[$];
      int unsigned errors;

      function new();
         gen_word  = word_type'(1);
         last_word = '0;
         errors    = 0;
         foreach (shuffle[i]) shuffle[i] = '0;
      endfunction

      static function word_type lehmer_step(word_type x);
         longint unsigned prod;
         prod = MULTIPLIER * longint'(x);
         return word_type'(prod % MODULUS);
      endfunction

      // Run the generator ENTRIES + WARM_EXTRA steps; the last ENTRIES steps fill
      // the table from the top entry down.
      function void warm_table(word_type start);
         word_type x;
         x = start;
         for (int j = ENTRIES + WARM_EXTRA - 1; j >= 0; j--) begin
            x = lehmer_step(x);
            if (j < ENTRIES) shuffle[j] = x;
         end
         gen_word  = x;
         last_word = shuffle[0];
      endfunction

      // Advance the prediction for one accepted request and owe its output.
      function void note_request(action_type act, logic [31:0] seed);
         logic [31:0] mag;
         word_type    start;
         int unsigned slot;
         word_type    picked;
         if (act == ACT_RESEED) begin
            start = word_type'(1);
            if (seed[31]) begin
               mag   = -seed;
               start = word_type'(longint'(mag) % MODULUS);
            end
            warm_table(start);
         end else if (last_word == '0 || gen_word == '0) begin
            warm_table(word_type'(1));
         end
         gen_word = lehmer_step(gen_word);
         slot     = int'(longint'(last_word) / SLOT_SPAN);
         if (slot >= ENTRIES) slot = ENTRIES - 1;
         picked        = shuffle[slot];
         shuffle[slot] = gen_word;
         last_word     = picked;
         owed_q.push_back(picked);
      endfunction

      function void check_output(logic [OUT_W-1:0] got);
         word_type want;
         if (owed_q.size() == 0) begin
            $error("rsp_random_value: output with no request waiting, actual %0d", got);
            errors++;
            return;
         end
         want = owed_q.pop_front();
         if (got !== want) begin
            $error("rsp_random_value: expected %0d, actual %0d", want, got);
            errors++;
         end
      endfunction

      function int owed();
         return owed_q.size();
      endfunction
   endclass

endpackage

### tb/tb.sv
// Top-level testbench for shuffled_lehmer_random_generator_unit: drives draws and reseeds,
// throttles the output side, and checks every output against the scoreboard prediction.
// Depends on slrg_pkg (port widths) and lehmer_tb_pkg (scoreboard, action codes).
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Longest stretch without any transaction before the run is declared hung. The slowest
   // correct stretch is the long output hold (LONG_HOLD) plus a reseed warm-up and both sides'
   // idle draws, so this leaves several times the margin.
   localparam int QUIET_LIMIT = 4000;
   // Settle time after the last output: a full warm-up plus slack.
   localparam int TAIL_CYCLES = 120;
   localparam int RANDOM_ITEMS = 1330;
   localparam int LONG_HOLD = 400;
   localparam int LONG_HOLD_AT = 200;

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_action = 1'b0;
   logic signed [31:0] req_seed  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [slrg_pkg::WORD_W-1:0] rsp_random_value;

   lehmer_tb_pkg::lehmer_scoreboard sb = new();

   int  quiet_cycles = 0;
   bit  send_fast    = 1'b0;
   bit  take_fast    = 1'b0;

   shuffled_lehmer_random_generator_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_seed         (req_seed),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_random_value (rsp_random_value)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Monitor: sample both channels at the edge with pre-edge values. Note the request
   // before checking the output; the block's latency keeps the two apart anyway.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_request(lehmer_tb_pkg::action_type'(req_action), req_seed);
         end
         if (rsp_valid && !rsp_stall) sb.check_output(rsp_random_value);
      end
   end

   // Watchdog: count cycles without any transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one transaction and hold it until the block takes it. The idle gap comes
   // first; in a fast stretch there is none, so valid stays high back to back.
   task automatic send_transaction(lehmer_tb_pkg::action_type act, logic [31:0] seed);
      int gap;
      if ($urandom_range(0, 39) == 0) send_fast = !send_fast;
      gap = send_fast ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_seed   <= seed;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // Drop valid and hold off until every owed output has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.owed() != 0);
   endtask

   // Output side: draw a stall for every output. Once, hold off for a long stretch
   // so the block backs up and stalls its request side while requests keep coming.
   task automatic take_outputs();
      int hold;
      int taken;
      taken = 0;
      forever begin
         if ($urandom_range(0, 39) == 0) take_fast = !take_fast;
         if (taken == LONG_HOLD_AT) hold = LONG_HOLD;
         else hold = take_fast ? 0 : $urandom_range(0, 9);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         taken++;
      end
   endtask

   function automatic logic [31:0] random_reseed_value();
      logic [31:0] s;
      s = $urandom();
      case ($urandom_range(0, 9))
         0:       s = 32'h8000_0001;           // start value of zero
         1:       s = 32'h8000_0000;           // negation wraps to 2^31
         2:       s = '0;
         3, 4, 5: s[31] = 1'b0;                // positive: start from one
         default: s[31] = 1'b1;                // negative: the usual reseed
      endcase
      return s;
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      fork
         take_outputs();
      join_none

      // Directed: unseeded draws straight out of reset
      send_transaction(lehmer_tb_pkg::ACT_DRAW, 32'h0000_0000);
      send_transaction(lehmer_tb_pkg::ACT_DRAW, 32'hFFFF_FFFF);
      // zero and positive seeds fall back to a start value of one
      send_transaction(lehmer_tb_pkg::ACT_RESEED, 32'h0000_0000);
      send_transaction(lehmer_tb_pkg::ACT_DRAW, 32'h7FFF_FFFF);
      send_transaction(lehmer_tb_pkg::ACT_RESEED, 32'h7FFF_FFFF);
      send_transaction(lehmer_tb_pkg::ACT_RESEED, 32'h0000_0001);
      // negative seeds: smallest magnitude, largest nonzero start
      send_transaction(lehmer_tb_pkg::ACT_RESEED, 32'hFFFF_FFFF);
      send_transaction(lehmer_tb_pkg::ACT_DRAW, 32'h5555_5555);
      send_transaction(lehmer_tb_pkg::ACT_RESEED, 32'h8000_0002);
      send_transaction(lehmer_tb_pkg::ACT_DRAW, 32'hAAAA_AAAA);
      // seed that starts the generator at zero, then a draw that must warm up again
      send_transaction(lehmer_tb_pkg::ACT_RESEED, 32'h8000_0001);
      send_transaction(lehmer_tb_pkg::ACT_DRAW, 32'h0000_0000);
      send_transaction(lehmer_tb_pkg::ACT_DRAW, 32'h0000_0000);
      // zero start followed directly by another zero start and a reseed
      send_transaction(lehmer_tb_pkg::ACT_RESEED, 32'h8000_0001);
      send_transaction(lehmer_tb_pkg::ACT_RESEED, 32'h8000_0001);
      send_transaction(lehmer_tb_pkg::ACT_RESEED, 32'hFFED_2979);
      // out-of-range seed whose negation wraps to 2^31
      send_transaction(lehmer_tb_pkg::ACT_RESEED, 32'h8000_0000);
      repeat (5) send_transaction(lehmer_tb_pkg::ACT_DRAW, $urandom());
      wait_for_drain();

      // Random: long runs of draws broken by occasional reseeds and drain pauses
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 600 || $urandom_range(0, 249) == 0) wait_for_drain();
         if ($urandom_range(0, 19) == 0) begin
            send_transaction(lehmer_tb_pkg::ACT_RESEED, random_reseed_value());
         end else begin
            send_transaction(lehmer_tb_pkg::ACT_DRAW, $urandom());
         end
      end

      // Wrap up: let the owed outputs arrive, then watch for strays
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.owed() != 0) $error("rsp_random_value: %0d outputs never arrived", sb.owed());
      if (sb.errors == 0 && sb.owed() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### sim.f
hdl/slrg_pkg.sv
hdl/slrg_modmul.sv
hdl/slrg_table.sv
hdl/shuffled_lehmer_random_generator_unit.sv
tb/lehmer_tb_pkg.sv
tb/tb.sv
